### hw/rtl/uer_pkg.sv
// Shared types, register indexes, status codes and the distance scaling for the echo ranger.
package uer_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int TIMEOUT_W  = 16;
    localparam int TRIG_W     = 8;
    localparam int PULSE_W    = 16;
    localparam int DIST_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd30000;
    localparam logic [TRIG_W-1:0]    TRIG_LOW_RST  = 8'd2;
    localparam logic [TRIG_W-1:0]    TRIG_HIGH_RST = 8'd10;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 2'd2;

    // Distance is pulse * 16 / 58 = (pulse * 8) / 29, done as a multiply by a
    // rounded-up reciprocal of 29 and a right shift; exact for all 20-bit dividends.
    localparam int DIST_SHIFT = 25;
    localparam int RECIP_W    = 21;
    localparam logic [RECIP_W-1:0] DIST_RECIP = 21'(((1 << DIST_SHIFT) + 28) / 29);
    localparam int DIVIDEND_W = PULSE_W + 3;
    localparam int PROD_W     = DIVIDEND_W + RECIP_W;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_RISE  = 2'd1,
        STATUS_NO_FALL  = 2'd2,
        STATUS_TOO_LONG = 2'd3
    } status_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_ticks;
        logic [TRIG_W-1:0]    trig_low_ticks;
        logic [TRIG_W-1:0]    trig_high_ticks;
    } cfg_t;

    typedef struct packed {
        logic                trig_level;
        logic                busy_res;
        logic                done_res;
        status_t             status;
        logic [PULSE_W-1:0]  pulse_ticks;
        logic [DIST_W-1:0]   distance_q4;
    } result_t;

    function automatic logic [DIST_W-1:0] dist_q4(input logic [PULSE_W-1:0] pulse);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'({pulse, 3'b000}) * PROD_W'(DIST_RECIP);
        return prod[DIST_SHIFT +: DIST_W];
    endfunction

endpackage

### hw/rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level: configuration registers, sequencer and output skid buffer.
// Each accepted result is registered in the output register, or in the skid entry under output stall.
// Throughput: one item per cycle while in_stall is low; the sequencer and distance multiply finish in a single pass.
// A two-entry output buffer (output register and skid entry) holds one item taken under output stall.
// Reset is asynchronous and active low; it restores the register defaults and an idle phase.
module ultrasonic_echo_ranger #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cmd,
    input  logic                             echo_level,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             trig_level,
    output logic                             busy_res,
    output logic                             done_res,
    output logic [1:0]                       status,
    output logic [uer_pkg::PULSE_W-1:0]      pulse_ticks,
    output logic [uer_pkg::DIST_W-1:0]       distance_q4,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data
);

    uer_pkg::cfg_t    cfg_reg;
    uer_pkg::result_t res;
    uer_pkg::result_t out_reg;
    uer_pkg::result_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             accept;
    logic             slot_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks   <= uer_pkg::TIMEOUT_RST;
            cfg_reg.trig_low_ticks  <= uer_pkg::TRIG_LOW_RST;
            cfg_reg.trig_high_ticks <= uer_pkg::TRIG_HIGH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                uer_pkg::REG_TIMEOUT:
                    cfg_reg.timeout_ticks <= cfg_data;
                uer_pkg::REG_TRIG_LOW:
                    cfg_reg.trig_low_ticks <= cfg_data[uer_pkg::TRIG_W-1:0];
                uer_pkg::REG_TRIG_HIGH:
                    cfg_reg.trig_high_ticks <= cfg_data[uer_pkg::TRIG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    uer_fsm #(
        .COUNT_BITS (COUNT_BITS)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .cmd        (cmd),
        .echo_level (echo_level),
        .cfg        (cfg_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (slot_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (slot_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (slot_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (slot_free)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign trig_level  = out_reg.trig_level;
    assign busy_res    = out_reg.busy_res;
    assign done_res    = out_reg.done_res;
    assign status      = out_reg.status;
    assign pulse_ticks = out_reg.pulse_ticks;
    assign distance_q4 = out_reg.distance_q4;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("transfer taken under output stall was not kept in the skid entry");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done_res) |-> (!out_reg.busy_res && !out_reg.trig_level))
        else $error("finished measurement still reported busy");

    a_idle_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.done_res) |->
            (out_reg.status == uer_pkg::STATUS_OK && out_reg.pulse_ticks == '0
             && out_reg.distance_q4 == '0))
        else $error("result fields set on a transfer that finishes no measurement");

endmodule

### hw/rtl/uer_fsm.sv
// Measurement sequencer: trigger timing, echo edge detection, timeouts and result forming.
module uer_fsm #(
    parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             cmd,
    input  logic             echo_level,
    input  uer_pkg::cfg_t    cfg,
    output uer_pkg::result_t res
);

    localparam int CMP_W = (COUNT_BITS > uer_pkg::TIMEOUT_W) ? COUNT_BITS : uer_pkg::TIMEOUT_W;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TLOW  = 3'd1,
        PH_THIGH = 3'd2,
        PH_WRISE = 3'd3,
        PH_MEAS  = 3'd4
    } phase_t;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  prev_echo_reg;

    logic                  rise;
    logic                  fall;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CMP_W-1:0]      inc_wide;
    logic                  over_timeout;
    logic                  done;
    uer_pkg::status_t      status;
    logic [uer_pkg::PULSE_W-1:0] pulse;
    phase_t                after_low;

    always_comb
    begin
        rise         = echo_level && !prev_echo_reg;
        fall         = !echo_level && prev_echo_reg;
        count_inc    = (count_reg == '1) ? count_reg : count_reg + 1'b1;
        inc_wide     = CMP_W'(count_inc);
        over_timeout = inc_wide > CMP_W'(cfg.timeout_ticks);
        after_low    = (cfg.trig_high_ticks == '0) ? PH_WRISE : PH_THIGH;
        phase_next   = phase_reg;
        count_next   = count_reg;
        done         = 1'b0;
        status       = uer_pkg::STATUS_OK;
        pulse        = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (cmd)
                begin
                    count_next = '0;
                    phase_next = (cfg.trig_low_ticks == '0) ? after_low : PH_TLOW;
                end
            end
            PH_TLOW:
            begin
                count_next = count_inc;
                if (inc_wide >= CMP_W'(cfg.trig_low_ticks))
                begin
                    count_next = '0;
                    phase_next = after_low;
                end
            end
            PH_THIGH:
            begin
                count_next = count_inc;
                if (inc_wide >= CMP_W'(cfg.trig_high_ticks))
                begin
                    count_next = '0;
                    phase_next = PH_WRISE;
                end
            end
            PH_WRISE:
            begin
                count_next = count_inc;
                if (rise)
                begin
                    count_next = '0;
                    phase_next = PH_MEAS;
                end
                else if (over_timeout)
                begin
                    done   = 1'b1;
                    status = uer_pkg::STATUS_NO_RISE;
                end
            end
            PH_MEAS:
            begin
                count_next = count_inc;
                if (fall)
                begin
                    done = 1'b1;
                    if (over_timeout)
                    begin
                        status = uer_pkg::STATUS_TOO_LONG;
                    end
                    else
                    begin
                        pulse = uer_pkg::PULSE_W'(inc_wide);
                    end
                end
                else if (over_timeout)
                begin
                    done   = 1'b1;
                    status = uer_pkg::STATUS_NO_FALL;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                count_next = '0;
            end
        endcase
        if (done)
        begin
            phase_next = PH_IDLE;
            count_next = '0;
        end
        res.trig_level  = (phase_next == PH_THIGH);
        res.busy_res    = (phase_next != PH_IDLE);
        res.done_res    = done;
        res.status      = status;
        res.pulse_ticks = pulse;
        res.distance_q4 = uer_pkg::dist_q4(pulse);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            prev_echo_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            prev_echo_reg <= echo_level;
        end
    end

endmodule
